// ----- rtl/core/emac_pkg.sv -----
// Package for the elementwise modular ALU: command codes, register indexes,
// the per-item control bundle that travels down the cell chains.
// No dependencies.
package emac_pkg;

    localparam int VALUE_WIDTH_DEF = 60;

    typedef enum logic [2:0] {
        CMD_ADD    = 3'd0,
        CMD_SUB    = 3'd1,
        CMD_MUL    = 3'd2,
        CMD_CENTER = 3'd3,
        CMD_SWITCH = 3'd4
    } t_cmd;

    localparam logic CFG_MODULUS = 1'b0;
    localparam logic CFG_TARGET  = 1'b1;

    typedef struct packed {
        logic       valid;
        logic [2:0] cmd;
        logic       last;
        logic       use_t;
        logic       a_gt_half;
        logic       a_lsb;
        logic       q_lt_t;
        logic       zero;
    } t_ctl;

endpackage

// ----- rtl/core/elementwise_modular_alu.sv -----
// Elementwise modular ALU: add, subtract, multiply mod q, centered reduce and
// modulus switch to t. Depends on emac_pkg, emac_rem_cell, emac_mul_cell.
// Pipeline: entry register, remainder chain, finalize register, multiply chain
// and output register; each cell in the remainder and multiply chains takes one bit.
// Throughput: one item per cycle; busy stays low and results cannot stall.
// Reset: synchronous, active low; clears the pipeline valid bits and sets
// modulus and target modulus to 2.
module elementwise_modular_alu #(
    parameter int VALUE_WIDTH = emac_pkg::VALUE_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [2:0]             i_command,
    input  logic [VALUE_WIDTH-1:0] i_operand_a,
    input  logic [VALUE_WIDTH-1:0] i_operand_b,
    input  logic                   i_last_element,
    input  logic                   i_cfg_we,
    input  logic                   i_cfg_index,
    input  logic [VALUE_WIDTH-1:0] i_cfg_data,
    output logic                   o_valid,
    output logic [VALUE_WIDTH-1:0] o_result_value,
    output logic                   o_result_last
);
    import emac_pkg::*;

    localparam int W = VALUE_WIDTH;

    function automatic logic [W-1:0] add_red(logic [W-1:0] x, logic [W-1:0] y,
                                             logic [W-1:0] m);
        logic [W:0] s;
        s = {1'b0, x} + {1'b0, y};
        if (s >= {1'b0, m}) begin
            s = s - {1'b0, m};
        end
        return s[W-1:0];
    endfunction

    function automatic logic [W-1:0] sub_red(logic [W-1:0] x, logic [W-1:0] y,
                                             logic [W-1:0] m);
        logic [W-1:0] r;
        if (x >= y) begin
            r = x - y;
        end else begin
            r = x + (m - y);
        end
        return r;
    endfunction

    logic [W-1:0] r_q, r_t;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q <= W'(2);
            r_t <= W'(2);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MODULUS: r_q <= i_cfg_data;
                CFG_TARGET:  r_t <= i_cfg_data;
                default:     ;
            endcase
        end
    end

    assign busy = 1'b0;

    // entry stage: pick second dividend and modulus, flag the upper half
    t_ctl         n_ctl0, r_ctl0;
    logic [W-1:0] n_b0, r_a0, r_b0, d;

    always_comb begin
        d = (r_q > r_t) ? (r_q - r_t) : (r_t - r_q);
        n_ctl0.valid     = start;
        n_ctl0.cmd       = i_command;
        n_ctl0.last      = i_last_element;
        n_ctl0.use_t     = (i_command == CMD_CENTER) || (i_command == CMD_SWITCH);
        n_ctl0.a_gt_half = i_operand_a > (r_q >> 1);
        n_ctl0.a_lsb     = i_operand_a[0];
        n_ctl0.q_lt_t    = r_q < r_t;
        n_ctl0.zero      = 1'b0;
        case (i_command)
            CMD_CENTER: n_b0 = r_q;
            CMD_SWITCH: n_b0 = d;
            default:    n_b0 = i_operand_b;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl0 <= '0;
        end else begin
            r_ctl0 <= n_ctl0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a0 <= i_operand_a;
        r_b0 <= n_b0;
    end

    // remainder chain
    t_ctl         rc_ctl [0:W];
    logic [W-1:0] rc_a   [0:W];
    logic [W-1:0] rc_b   [0:W];
    logic [W-1:0] rc_ra  [0:W];
    logic [W-1:0] rc_rb  [0:W];

    assign rc_ctl[0] = r_ctl0;
    assign rc_a[0]   = r_a0;
    assign rc_b[0]   = r_b0;
    assign rc_ra[0]  = '0;
    assign rc_rb[0]  = '0;

    for (genvar k = 0; k < W; k++) begin : g_rem
        emac_rem_cell #(.W(W), .IDX(W - 1 - k)) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_ctl  (rc_ctl[k]),
            .i_q    (r_q),
            .i_t    (r_t),
            .i_a    (rc_a[k]),
            .i_b    (rc_b[k]),
            .i_ra   (rc_ra[k]),
            .i_rb   (rc_rb[k]),
            .o_ctl  (rc_ctl[k+1]),
            .o_a    (rc_a[k+1]),
            .o_b    (rc_b[k+1]),
            .o_ra   (rc_ra[k+1]),
            .o_rb   (rc_rb[k+1])
        );
    end

    // finalize add, subtract and the reductions to t; seed the multiply
    t_ctl         n_ctl1, r_ctl1;
    logic [W-1:0] n_res1, r_res1, r_x1, r_y1;
    logic [W-1:0] ra, rb;

    always_comb begin
        ra = rc_ra[W];
        rb = rc_rb[W];
        n_ctl1 = rc_ctl[W];
        n_ctl1.zero = 1'b0;
        n_res1 = '0;
        case (rc_ctl[W].cmd)
            CMD_ADD: begin
                if (r_q != '0) n_res1 = add_red(ra, rb, r_q);
            end
            CMD_SUB: begin
                if (r_q != '0) n_res1 = sub_red(ra, rb, r_q);
            end
            CMD_MUL: begin
                n_ctl1.zero = (r_q == '0);
            end
            CMD_CENTER: begin
                if (r_t == W'(2)) begin
                    n_res1 = W'(rc_ctl[W].a_lsb ^ rc_ctl[W].a_gt_half);
                end else if (r_t != '0) begin
                    n_res1 = rc_ctl[W].a_gt_half ? sub_red(ra, rb, r_t) : ra;
                end
            end
            CMD_SWITCH: begin
                if (r_t != '0) begin
                    if (!rc_ctl[W].a_gt_half) begin
                        n_res1 = ra;
                    end else if (rc_ctl[W].q_lt_t) begin
                        n_res1 = add_red(ra, rb, r_t);
                    end else begin
                        n_res1 = sub_red(ra, rb, r_t);
                    end
                end
            end
            default: n_res1 = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl1 <= '0;
        end else begin
            r_ctl1 <= n_ctl1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res1 <= n_res1;
        r_x1   <= ra;
        r_y1   <= rb;
    end

    // multiply chain
    t_ctl         mc_ctl [0:W];
    logic [W-1:0] mc_x   [0:W];
    logic [W-1:0] mc_y   [0:W];
    logic [W-1:0] mc_acc [0:W];
    logic [W-1:0] mc_res [0:W];

    assign mc_ctl[0] = r_ctl1;
    assign mc_x[0]   = r_x1;
    assign mc_y[0]   = r_y1;
    assign mc_acc[0] = '0;
    assign mc_res[0] = r_res1;

    for (genvar k = 0; k < W; k++) begin : g_mul
        emac_mul_cell #(.W(W), .IDX(W - 1 - k)) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_ctl  (mc_ctl[k]),
            .i_q    (r_q),
            .i_x    (mc_x[k]),
            .i_y    (mc_y[k]),
            .i_acc  (mc_acc[k]),
            .i_res  (mc_res[k]),
            .o_ctl  (mc_ctl[k+1]),
            .o_x    (mc_x[k+1]),
            .o_y    (mc_y[k+1]),
            .o_acc  (mc_acc[k+1]),
            .o_res  (mc_res[k+1])
        );
    end

    // output register: pick the product or the finished residue
    logic         r_valid, r_last;
    logic [W-1:0] n_value, r_value;

    always_comb begin
        if (mc_ctl[W].zero) begin
            n_value = '0;
        end else if (mc_ctl[W].cmd == CMD_MUL) begin
            n_value = mc_acc[W];
        end else begin
            n_value = mc_res[W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= mc_ctl[W].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        r_last  <= mc_ctl[W].last;
    end

    assign o_valid        = r_valid;
    assign o_result_value = r_value;
    assign o_result_last  = r_last;

endmodule

// ----- rtl/core/emac_rem_cell.sv -----
// One remainder cell: takes one dividend bit into two running remainders.
// Depends on emac_pkg.
module emac_rem_cell #(
    parameter int W   = emac_pkg::VALUE_WIDTH_DEF,
    parameter int IDX = 0
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  emac_pkg::t_ctl  i_ctl,
    input  logic [W-1:0]    i_q,
    input  logic [W-1:0]    i_t,
    input  logic [W-1:0]    i_a,
    input  logic [W-1:0]    i_b,
    input  logic [W-1:0]    i_ra,
    input  logic [W-1:0]    i_rb,
    output emac_pkg::t_ctl  o_ctl,
    output logic [W-1:0]    o_a,
    output logic [W-1:0]    o_b,
    output logic [W-1:0]    o_ra,
    output logic [W-1:0]    o_rb
);
    import emac_pkg::*;

    logic [W-1:0] m;
    logic [W:0]   sa, sb;
    logic [W-1:0] n_ra, n_rb;
    t_ctl         r_ctl;
    logic [W-1:0] r_a, r_b, r_ra, r_rb;

    // shift in the next bit and subtract the modulus once
    always_comb begin
        m = i_ctl.use_t ? i_t : i_q;
        sa = {i_ra, i_a[IDX]};
        sb = {i_rb, i_b[IDX]};
        if (sa >= {1'b0, m}) begin
            sa = sa - {1'b0, m};
        end
        if (sb >= {1'b0, m}) begin
            sb = sb - {1'b0, m};
        end
        n_ra = sa[W-1:0];
        n_rb = sb[W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a  <= i_a;
        r_b  <= i_b;
        r_ra <= n_ra;
        r_rb <= n_rb;
    end

    assign o_ctl = r_ctl;
    assign o_a   = r_a;
    assign o_b   = r_b;
    assign o_ra  = r_ra;
    assign o_rb  = r_rb;

endmodule

// ----- rtl/core/emac_mul_cell.sv -----
// One modular multiply cell: double the accumulator, add x on a set bit of y.
// Depends on emac_pkg.
module emac_mul_cell #(
    parameter int W   = emac_pkg::VALUE_WIDTH_DEF,
    parameter int IDX = 0
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  emac_pkg::t_ctl  i_ctl,
    input  logic [W-1:0]    i_q,
    input  logic [W-1:0]    i_x,
    input  logic [W-1:0]    i_y,
    input  logic [W-1:0]    i_acc,
    input  logic [W-1:0]    i_res,
    output emac_pkg::t_ctl  o_ctl,
    output logic [W-1:0]    o_x,
    output logic [W-1:0]    o_y,
    output logic [W-1:0]    o_acc,
    output logic [W-1:0]    o_res
);
    import emac_pkg::*;

    logic [W:0]   dbl, s;
    logic [W-1:0] n_acc;
    t_ctl         r_ctl;
    logic [W-1:0] r_x, r_y, r_acc, r_res;

    // double mod q, then add x mod q where this bit of y is set
    always_comb begin
        dbl = {i_acc, 1'b0};
        if (dbl >= {1'b0, i_q}) begin
            dbl = dbl - {1'b0, i_q};
        end
        s = {1'b0, dbl[W-1:0]} + {1'b0, i_x};
        if (s >= {1'b0, i_q}) begin
            s = s - {1'b0, i_q};
        end
        n_acc = i_y[IDX] ? s[W-1:0] : dbl[W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x   <= i_x;
        r_y   <= i_y;
        r_acc <= n_acc;
        r_res <= i_res;
    end

    assign o_ctl = r_ctl;
    assign o_x   = r_x;
    assign o_y   = r_y;
    assign o_acc = r_acc;
    assign o_res = r_res;

endmodule
